>>> design/swam_pkg.sv
// shared constants, register indexes and controller/datapath interface types
// for the sliding window average / max block; no dependencies
`timescale 1ns / 1ps

package swam_pkg;

  // ring size and derived widths
  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int DIV_CNT_W  = $clog2(DATA_W);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_LEN_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;

  localparam logic                 MODE_AVG       = 1'b0;
  localparam logic                 MODE_MAX       = 1'b1;
  localparam logic [CFG_LEN_W-1:0] WINDOW_LEN_RST = 7'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic avg_sum;    // update running sum, write sample to ring
    logic div_init;   // load divider from running sum
    logic div_step;   // one quotient bit
    logic walk_step;  // one ring read / compare of the max walk
    logic out_load;   // load output register
    logic cfg_write;  // configuration transfer this cycle
  } swam_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mode_max;
    logic walk_done;
  } swam_status_t;

endpackage

>>> design/swam_ram.sv
// generic single write port / single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module swam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/swam_dp.sv
// datapath: config registers, ring pointers, running sum, serial divider,
// max walk and output payload register; uses swam_pkg and swam_ram
`timescale 1ns / 1ps

module swam_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  swam_pkg::swam_cmd_t                    cmd_i,
  output swam_pkg::swam_status_t                 status_o,
  input  logic signed [swam_pkg::DATA_W-1:0]     sample_i,
  input  logic                                   sample_defined_i,
  input  logic [swam_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [swam_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic signed [swam_pkg::DATA_W-1:0]     result_value_o,
  output logic                                   result_valid_o
);

  localparam int DW = swam_pkg::DATA_W;
  localparam int AW = swam_pkg::ADDR_W;
  localparam int LW = swam_pkg::LEN_W;

  // config and window state
  logic                            mode_q;
  logic [swam_pkg::CFG_LEN_W-1:0]  window_len_q;
  logic [DW-1:0]                   sum_q, sum_d;
  logic [AW-1:0]                   write_pos_q;
  logic [LW-1:0]                   fill_q;
  logic [swam_pkg::WINDOW_MAX-1:0] ring_vld_q;

  // per item
  logic signed [DW-1:0] x_q;
  logic                 def_q;
  logic                 full_q;
  logic [AW-1:0]        pos_q;
  logic                 old_vld_q;
  logic signed [DW-1:0] best_q;
  logic [AW-1:0]        walk_addr_q;
  logic [LW-1:0]        walk_rem_q;
  logic                 walk_pend_q;
  logic [DW-1:0]        dq_q;
  logic [LW-1:0]        rem_q;
  logic                 neg_q;

  logic signed [DW-1:0] result_value_q, result_value_d;
  logic                 result_valid_q;

  logic [LW-1:0] n_c;
  logic [AW-1:0] pos_c;
  logic [AW-1:0] pos_inc_c;
  logic [AW-1:0] n_last_c;
  logic [LW-1:0] fill_new_c;
  logic          cfg_clear_c;
  logic          ram_we_c;
  logic [AW-1:0] ram_waddr_c;
  logic [DW-1:0] ram_wdata_c;
  logic [AW-1:0] ram_raddr_c;
  logic [DW-1:0] ram_rdata;
  logic [DW-1:0] old_c;
  logic [LW:0]   trial_c;
  logic          qbit_c;

  // effective window length: zero acts as one, saturate at ring size
  always_comb begin
    if (window_len_q == '0) begin
      n_c = LW'(1);
    end else if (int'(window_len_q) > swam_pkg::WINDOW_MAX) begin
      n_c = LW'(swam_pkg::WINDOW_MAX);
    end else begin
      n_c = LW'(window_len_q);
    end
  end

  assign n_last_c   = AW'(n_c - LW'(1));
  assign pos_c      = ({1'b0, write_pos_q} >= {1'b0, n_c}) ? '0 : write_pos_q;
  assign pos_inc_c  = ((LW'(pos_c) + LW'(1)) >= n_c) ? '0 : AW'(pos_c + AW'(1));
  assign fill_new_c = (fill_q < n_c) ? LW'(fill_q + LW'(1)) : n_c;

  // config write of a known register clears the window
  always_comb begin
    cfg_clear_c = 1'b0;
    if (cmd_i.cfg_write) begin
      unique case (cfg_index_i)
        swam_pkg::CFG_MODE:       cfg_clear_c = 1'b1;
        swam_pkg::CFG_WINDOW_LEN: cfg_clear_c = 1'b1;
        default:                  cfg_clear_c = 1'b0;
      endcase
    end
  end

  // ring access
  assign ram_we_c    = (cmd_i.accept && sample_defined_i && (mode_q == swam_pkg::MODE_MAX))
                       || cmd_i.avg_sum;
  assign ram_waddr_c = cmd_i.accept ? pos_c : pos_q;
  assign ram_wdata_c = cmd_i.accept ? sample_i : x_q;
  assign ram_raddr_c = cmd_i.accept ? pos_c : walk_addr_q;

  swam_ram #(
    .WIDTH (DW),
    .DEPTH (swam_pkg::WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we_c),
    .waddr_i (ram_waddr_c),
    .wdata_i (ram_wdata_c),
    .raddr_i (ram_raddr_c),
    .rdata_o (ram_rdata)
  );

  assign old_c = old_vld_q ? ram_rdata : '0;
  assign sum_d = sum_q + x_q - old_c;

  // restoring divider step
  assign trial_c = {rem_q, dq_q[DW-1]};
  assign qbit_c  = (trial_c >= {1'b0, n_c});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= swam_pkg::MODE_AVG;
      window_len_q <= swam_pkg::WINDOW_LEN_RST;
      sum_q        <= '0;
      write_pos_q  <= '0;
      fill_q       <= '0;
      ring_vld_q   <= '0;
      walk_rem_q   <= '0;
      walk_pend_q  <= 1'b0;
    end else if (cfg_clear_c) begin
      if (cfg_index_i == swam_pkg::CFG_MODE) begin
        mode_q <= cfg_data_i[0];
      end else begin
        window_len_q <= swam_pkg::CFG_LEN_W'(cfg_data_i);
      end
      sum_q       <= '0;
      write_pos_q <= '0;
      fill_q      <= '0;
      ring_vld_q  <= '0;
    end else begin
      if (cmd_i.accept && sample_defined_i) begin
        write_pos_q <= pos_inc_c;
        fill_q      <= fill_new_c;
        walk_rem_q  <= LW'(fill_new_c - LW'(1));
        walk_pend_q <= 1'b0;
        if (mode_q == swam_pkg::MODE_MAX) begin
          ring_vld_q[pos_c] <= 1'b1;
        end
      end
      if (cmd_i.avg_sum) begin
        sum_q             <= sum_d;
        ring_vld_q[pos_q] <= 1'b1;
      end
      if (cmd_i.walk_step) begin
        walk_pend_q <= (walk_rem_q != '0);
        if (walk_rem_q != '0) begin
          walk_rem_q <= LW'(walk_rem_q - LW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q         <= sample_i;
      def_q       <= sample_defined_i;
      full_q      <= (fill_new_c >= n_c);
      pos_q       <= pos_c;
      old_vld_q   <= ring_vld_q[pos_c];
      best_q      <= sample_i;
      walk_addr_q <= (pos_c == '0) ? n_last_c : AW'(pos_c - AW'(1));
    end
    if (cmd_i.walk_step) begin
      if (walk_pend_q && ($signed(ram_rdata) > best_q)) begin
        best_q <= $signed(ram_rdata);
      end
      if (walk_rem_q != '0) begin
        walk_addr_q <= (walk_addr_q == '0) ? n_last_c : AW'(walk_addr_q - AW'(1));
      end
    end
    if (cmd_i.div_init) begin
      neg_q <= sum_q[DW-1];
      dq_q  <= sum_q[DW-1] ? (~sum_q + DW'(1)) : sum_q;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      dq_q  <= {dq_q[DW-2:0], qbit_c};
      rem_q <= qbit_c ? LW'(trial_c - {1'b0, n_c}) : LW'(trial_c);
    end
    if (cmd_i.out_load) begin
      result_value_q <= result_value_d;
      result_valid_q <= def_q & full_q;
    end
  end

  always_comb begin
    if (!def_q) begin
      result_value_d = '0;
    end else if (mode_q == swam_pkg::MODE_MAX) begin
      result_value_d = best_q;
    end else begin
      result_value_d = neg_q ? $signed(~dq_q + DW'(1)) : $signed(dq_q);
    end
  end

  assign status_o.mode_max  = (mode_q == swam_pkg::MODE_MAX);
  assign status_o.walk_done = (walk_rem_q == '0) && !walk_pend_q;

  assign result_value_o = result_value_q;
  assign result_valid_o = result_valid_q;

endmodule

>>> design/swam_ctrl.sv
// controller: item sequencing state machine, divider step count and
// output valid flag; uses swam_pkg
`timescale 1ns / 1ps

module swam_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   sample_defined_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  swam_pkg::swam_status_t status_i,
  output swam_pkg::swam_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [swam_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           idle_c;

  assign idle_c = (state_q == S_IDLE);

  // an offered input transfer wins over a config write in the same cycle
  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = idle_c && in_valid_i;
    cmd_o.cfg_write = idle_c && cfg_valid_i && !in_valid_i;
    state_d         = state_q;
    div_cnt_d       = div_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!sample_defined_i) begin
            state_d = S_FIN;
          end else if (status_i.mode_max) begin
            state_d = S_WALK;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        cmd_o.avg_sum = 1'b1;
        state_d       = S_INIT;
      end
      S_INIT: begin
        cmd_o.div_init = 1'b1;
        div_cnt_d      = swam_pkg::DIV_CNT_W'(swam_pkg::DATA_W - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          div_cnt_d = div_cnt_q - swam_pkg::DIV_CNT_W'(1);
        end
      end
      S_WALK: begin
        if (status_i.walk_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !idle_c;
  assign cfg_ready_o = idle_c && !in_valid_i;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_avg_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sample_defined_i && !status_i.mode_max) |=> (state_q == S_SUM))
    else $error("average item did not enter the sum state");
  a_init_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |=> (state_q == S_DIV) && (div_cnt_q != '0))
    else $error("divider not started with a full step count");
  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (div_cnt_q != '0) |=> (state_q == S_DIV))
    else $error("divider left before all quotient bits");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register loaded while a stalled result waits");
`endif

endmodule

>>> design/sliding_window_avg_max.sv
// top level of the sliding window moving average / sliding maximum block
// instantiates swam_ctrl and swam_dp; uses swam_pkg
`timescale 1ns / 1ps

// usage
//   input channel: sample_i / sample_defined_i, transfer when in_valid_i is high
//   and in_stall_o is low. output channel: result_value_o / result_valid_o,
//   transfer when out_valid_o is high and out_stall_i is low.
//   config channel: cfg_index_i selects mode (0) or window_len (1), written
//   with cfg_data_i when cfg_valid_i and cfg_ready_o are high; cfg_ready_o is
//   low while an item is in flight or an input transfer is offered. a write
//   to a known index clears ring, running sum, write position and fill count.
// timing (one item at a time, input taken again the cycle after the result load)
//   average mode: the item passes the sum, divider load, divider and final
//   load states in that order; the divider is a 64-step one-bit-per-cycle
//   restoring divider.
//   max mode: the item passes the walk and final load states; the walk reads
//   the older window entries over the ring's single read port, one stored
//   entry per cycle, and reads none when only the new sample is in the window.
//   absent sample: straight to the final load, result 0 with result_valid low.
// reset: mode average, window_len 4, window empty; per-entry valid bits make
//   never-written ring entries read as zero, so there is no clearing pass.
// stall: a finished result waits in the output register; the next item is
//   already accepted and worked on, and only its final load waits for space.

module sliding_window_avg_max (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [swam_pkg::DATA_W-1:0]    sample_i,
  input  logic                                  sample_defined_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [swam_pkg::DATA_W-1:0]    result_value_o,
  output logic                                  result_valid_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [swam_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [swam_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // command and status between sequencer and datapath
  swam_pkg::swam_cmd_t    cmd;
  swam_pkg::swam_status_t status;

  // sequencer: accepts transfers, steps divider or max walk, loads output
  swam_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .sample_defined_i (sample_defined_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  // datapath: ring memory, running sum, divider, max compare, output payload
  swam_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_i         (sample_i),
    .sample_defined_i (sample_defined_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_value_o   (result_value_o),
    .result_valid_o   (result_valid_o)
  );

endmodule
